// ===== rtl/apic_pkg.sv =====
// ----------------------------------------------------------------------------
// apic_pkg
// Shared types and constants of the adaptive poll interval controller:
// register indexes, threat codes, controller states, command and status
// groups, and the Q1.16 factor tables.
// ----------------------------------------------------------------------------
package apic_pkg;

  localparam int RATE_BITS       = 16;
  localparam int CPU_BITS        = 16;
  localparam int FACTOR_BITS     = 17;
  localparam int Q16_SHIFT       = 16;
  localparam int FRAC_BITS       = 17;
  localparam int THRESH_BITS     = 48;
  localparam int CPU_LIMIT_BITS  = 32;
  localparam int CFG_INDEX_BITS  = 3;
  localparam int CFG_DATA_MIN    = 48;

  // Reset values of the configuration registers
  localparam int                      RST_BASE_INTERVAL = 1000;
  localparam int                      RST_MIN_INTERVAL  = 100;
  localparam int                      RST_MAX_INTERVAL  = 10000;
  localparam longint                  RST_COOLDOWN      = 5000;
  localparam logic [FRAC_BITS-1:0]    RST_MIN_CHANGE    = 17'd6554;
  localparam logic [THRESH_BITS-1:0]  RST_THRESHOLDS    = 48'h1000_0400_0100;
  localparam logic [CPU_LIMIT_BITS-1:0] RST_CPU_LIMITS  = 32'h5000_1400;

  // 1.0 in Q1.16 for the minimum-change fraction
  localparam logic [FRAC_BITS-1:0] FRAC_ONE = 17'd65536;

  typedef logic [FACTOR_BITS-1:0] factor_t;

  typedef enum logic [1:0] {
    THREAT_LOW      = 2'd0,
    THREAT_MEDIUM   = 2'd1,
    THREAT_HIGH     = 2'd2,
    THREAT_CRITICAL = 2'd3
  } threat_t;

  // Q1.16 factors indexed by threat level
  localparam factor_t FACTOR_NORMAL [4] = '{17'd65536, 17'd45875, 17'd21627, 17'd13107};
  localparam factor_t FACTOR_HOT    [4] = '{17'd98304, 17'd68813, 17'd32440, 17'd19661};
  localparam factor_t FACTOR_IDLE   [4] = '{17'd65536, 17'd45875, 17'd17302, 17'd10486};

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_ENABLE          = 3'd0,
    REG_BASE_INTERVAL   = 3'd1,
    REG_MIN_INTERVAL    = 3'd2,
    REG_MAX_INTERVAL    = 3'd3,
    REG_COOLDOWN        = 3'd4,
    REG_MIN_CHANGE_FRAC = 3'd5,
    REG_RATE_THRESHOLDS = 3'd6,
    REG_CPU_LIMITS      = 3'd7
  } apic_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_SCALE = 2'd1,
    ST_CLAMP = 2'd2,
    ST_CHECK = 2'd3
  } apic_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic scale;
    logic clamp;
    logic commit;
  } apic_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
  } apic_sts_t;

endpackage

// ===== rtl/apic_ifs.sv =====
// ----------------------------------------------------------------------------
// apic channel interfaces
// Valid/ready channels of the controller: update input, result output and
// configuration write.
// ----------------------------------------------------------------------------
interface apic_upd_if #(
  parameter int TIME_BITS = 32
);
  logic                 valid;
  logic                 ready;
  logic [15:0]          detection_rate;
  logic signed [15:0]   cpu_percent;
  logic [TIME_BITS-1:0] now_ms;

  modport source (output valid, detection_rate, cpu_percent, now_ms, input ready);
  modport sink   (input valid, detection_rate, cpu_percent, now_ms, output ready);
endinterface

interface apic_res_if #(
  parameter int INTERVAL_BITS = 20
);
  logic                     valid;
  logic                     ready;
  logic [1:0]               threat_level;
  logic [INTERVAL_BITS-1:0] recommended_interval;
  logic                     interval_applied;
  logic [INTERVAL_BITS-1:0] current_interval;

  modport source (output valid, threat_level, recommended_interval, interval_applied,
                  current_interval, input ready);
  modport sink   (input valid, threat_level, recommended_interval, interval_applied,
                  current_interval, output ready);
endinterface

interface apic_cfg_if #(
  parameter int DATA_BITS = 48
);
  logic                 valid;
  logic                 ready;
  logic [2:0]           index;
  logic [DATA_BITS-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/adaptive_poll_interval_ctrl_core.sv =====
// ----------------------------------------------------------------------------
// adaptive_poll_interval_ctrl_core
// Adaptive poll interval controller: grades detection rate and CPU load
// into a recommended polling interval and applies it under cooldown and
// minimum-change rules.
// ----------------------------------------------------------------------------
// Usage:
//   upd  - update channel (detection_rate, cpu_percent, now_ms); a transfer
//          takes place when valid and ready are both high.
//   res  - one result per update (threat_level, recommended_interval,
//          interval_applied, current_interval).
//   cfg  - register writes by index; always ready. Write only while idle.
// Sequence: an update passes the steps load, scale, clamp and check into the
//   result register, and the next update is taken only once the check step
//   has committed; the steps share one 17 x INTERVAL_BITS multiplier
//   between scaling and the change test.
// Stall: while a result waits, the next update is still taken and worked
//   up to the check step, which holds until the result register frees.
// Reset: registers return to their default values, the current interval
//   falls back to the base interval and the change stamp clears to zero.
// ----------------------------------------------------------------------------
module adaptive_poll_interval_ctrl_core
  import apic_pkg::*;
#(
  parameter int INTERVAL_BITS = 20,
  parameter int TIME_BITS     = 32
) (
  input  logic       clk,
  input  logic       rst,
  apic_cfg_if.sink   cfg,
  apic_upd_if.sink   upd,
  apic_res_if.source res
);

  apic_cmd_t cmd;
  apic_sts_t sts;

  // Configuration writes are always accepted
  assign cfg.ready = 1'b1;

  apic_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .upd_valid (upd.valid),
    .upd_ready (upd.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  apic_dp #(
    .INTERVAL_BITS (INTERVAL_BITS),
    .TIME_BITS     (TIME_BITS)
  ) u_dp (
    .clk                  (clk),
    .rst                  (rst),
    .cmd                  (cmd),
    .sts                  (sts),
    .cfg_valid            (cfg.valid),
    .cfg_index            (cfg.index),
    .cfg_data             (cfg.data),
    .detection_rate       (upd.detection_rate),
    .cpu_percent          (upd.cpu_percent),
    .now_ms               (upd.now_ms),
    .res_ready            (res.ready),
    .res_valid            (res.valid),
    .threat_level         (res.threat_level),
    .recommended_interval (res.recommended_interval),
    .interval_applied     (res.interval_applied),
    .current_interval     (res.current_interval)
  );

endmodule

// ===== rtl/apic_ctrl.sv =====
// ----------------------------------------------------------------------------
// apic_ctrl
// Sequencer of the controller: accept an update, scale, clamp, then check
// and commit once the result register is free.
// ----------------------------------------------------------------------------
module apic_ctrl
  import apic_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      upd_valid,
  output logic      upd_ready,
  input  apic_sts_t sts,
  output apic_cmd_t cmd
);

  apic_state_t state;
  apic_state_t state_next;

  // Hold the state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Advance through the steps of one update
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (upd_valid) state_next = ST_SCALE;
      end
      ST_SCALE: begin
        state_next = ST_CLAMP;
      end
      ST_CLAMP: begin
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Drive commands for the current step
  always_comb begin
    upd_ready  = 1'b0;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        upd_ready = 1'b1;
        cmd.load  = upd_valid;
      end
      ST_SCALE: begin
        cmd.scale = 1'b1;
      end
      ST_CLAMP: begin
        cmd.clamp = 1'b1;
      end
      ST_CHECK: begin
        cmd.commit = sts.out_free;
      end
      default: begin
        upd_ready = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/apic_dp.sv =====
// ----------------------------------------------------------------------------
// apic_dp
// Datapath of the controller: configuration registers, threat and factor
// selection, one shared multiplier for scaling and the change test, the
// interval state and the result register.
// ----------------------------------------------------------------------------
module apic_dp
  import apic_pkg::*;
#(
  parameter int INTERVAL_BITS = 20,
  parameter int TIME_BITS     = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  apic_cmd_t                     cmd,
  output apic_sts_t                     sts,
  input  logic                          cfg_valid,
  input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [((TIME_BITS > CFG_DATA_MIN) ? TIME_BITS : CFG_DATA_MIN)-1:0] cfg_data,
  input  logic [RATE_BITS-1:0]          detection_rate,
  input  logic signed [CPU_BITS-1:0]    cpu_percent,
  input  logic [TIME_BITS-1:0]          now_ms,
  input  logic                          res_ready,
  output logic                          res_valid,
  output logic [1:0]                    threat_level,
  output logic [INTERVAL_BITS-1:0]      recommended_interval,
  output logic                          interval_applied,
  output logic [INTERVAL_BITS-1:0]      current_interval
);

  localparam int IB        = INTERVAL_BITS;
  localparam int PROD_BITS = INTERVAL_BITS + FACTOR_BITS;
  localparam int COOL_BITS = 32;
  localparam int CMP_BITS  = (TIME_BITS > COOL_BITS) ? TIME_BITS : COOL_BITS;

  // Configuration registers
  logic                      enable;
  logic [IB-1:0]             base_interval;
  logic [IB-1:0]             min_interval;
  logic [IB-1:0]             max_interval;
  logic [COOL_BITS-1:0]      cooldown_ms;
  logic [FRAC_BITS-1:0]      min_change_frac;
  logic [THRESH_BITS-1:0]    rate_thresholds;
  logic [CPU_LIMIT_BITS-1:0] cpu_limits;

  // Controller state
  logic [IB-1:0]             active_interval;
  logic [TIME_BITS-1:0]      last_change_stamp;
  threat_t                   stored_threat;

  // Working registers of one update
  threat_t                   threat;
  factor_t                   factor;
  logic                      cool_ok;
  logic [TIME_BITS-1:0]      now_q;
  logic [IB:0]               scaled;
  logic [IB-1:0]             rec;
  logic [IB-1:0]             diff;

  // Combinational signals
  logic [CPU_BITS-1:0]       cpu_eff;
  logic [15:0]               thr_med;
  logic [15:0]               thr_high;
  logic [15:0]               thr_crit;
  logic [15:0]               cpu_low;
  logic [15:0]               cpu_high;
  threat_t                   threat_next;
  factor_t                   factor_next;
  logic [TIME_BITS-1:0]      elapsed;
  logic [IB-1:0]             cur_iv;
  logic [IB-1:0]             mul_a;
  logic [FACTOR_BITS-1:0]    mul_b;
  logic [PROD_BITS-1:0]      prod;
  logic [IB:0]               iv_min;
  logic [IB-1:0]             rec_next;
  logic [PROD_BITS-1:0]      diff_scaled;
  logic                      change_ok;
  logic                      apply;

  // Take configuration writes; the channel never stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      enable          <= 1'b1;
      base_interval   <= IB'(RST_BASE_INTERVAL);
      min_interval    <= IB'(RST_MIN_INTERVAL);
      max_interval    <= IB'(RST_MAX_INTERVAL);
      cooldown_ms     <= COOL_BITS'(RST_COOLDOWN);
      min_change_frac <= RST_MIN_CHANGE;
      rate_thresholds <= RST_THRESHOLDS;
      cpu_limits      <= RST_CPU_LIMITS;
    end else if (cfg_valid) begin
      case (apic_reg_t'(cfg_index))
        REG_ENABLE:          enable          <= cfg_data[0];
        REG_BASE_INTERVAL:   base_interval   <= cfg_data[IB-1:0];
        REG_MIN_INTERVAL:    min_interval    <= cfg_data[IB-1:0];
        REG_MAX_INTERVAL:    max_interval    <= cfg_data[IB-1:0];
        REG_COOLDOWN:        cooldown_ms     <= cfg_data[COOL_BITS-1:0];
        REG_MIN_CHANGE_FRAC: min_change_frac <= cfg_data[FRAC_BITS-1:0];
        REG_RATE_THRESHOLDS: rate_thresholds <= cfg_data[THRESH_BITS-1:0];
        REG_CPU_LIMITS:      cpu_limits      <= cfg_data[CPU_LIMIT_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  assign thr_med  = rate_thresholds[15:0];
  assign thr_high = rate_thresholds[31:16];
  assign thr_crit = rate_thresholds[47:32];
  assign cpu_low  = cpu_limits[15:0];
  assign cpu_high = cpu_limits[31:16];

  // Treat a missing (negative) CPU reading as zero
  assign cpu_eff = cpu_percent[CPU_BITS-1] ? '0 : CPU_BITS'(unsigned'(cpu_percent));

  // Grade the detection rate, highest threshold first
  always_comb begin
    if (detection_rate >= thr_crit) begin
      threat_next = THREAT_CRITICAL;
    end else if (detection_rate >= thr_high) begin
      threat_next = THREAT_HIGH;
    end else if (detection_rate >= thr_med) begin
      threat_next = THREAT_MEDIUM;
    end else begin
      threat_next = THREAT_LOW;
    end
  end

  // Pick the factor by CPU band; a hot CPU wins over an idle one
  always_comb begin
    if (cpu_eff >= cpu_high) begin
      factor_next = FACTOR_HOT[threat_next];
    end else if ((cpu_eff != '0) && (cpu_eff <= cpu_low) &&
                 ((threat_next == THREAT_HIGH) || (threat_next == THREAT_CRITICAL))) begin
      factor_next = FACTOR_IDLE[threat_next];
    end else begin
      factor_next = FACTOR_NORMAL[threat_next];
    end
  end

  // Time since the last applied change, modulo the timestamp width
  assign elapsed = now_ms - last_change_stamp;

  // Interval in force; zero means the base interval
  assign cur_iv = (active_interval != '0) ? active_interval : base_interval;

  // Share one multiplier: base times factor, then fraction times current
  assign mul_a = cmd.scale ? base_interval : cur_iv;
  assign mul_b = cmd.scale ? factor : min_change_frac;
  assign prod  = PROD_BITS'(mul_a) * PROD_BITS'(mul_b);

  // Clamp to min first, then max
  always_comb begin
    iv_min = (scaled < {1'b0, min_interval}) ? {1'b0, min_interval} : scaled;
    if (iv_min > {1'b0, max_interval}) begin
      rec_next = max_interval;
    end else begin
      rec_next = iv_min[IB-1:0];
    end
  end

  // Compare the change against the minimum fraction by cross-multiplication
  assign diff_scaled = {1'b0, diff, {Q16_SHIFT{1'b0}}};
  assign change_ok   = (cur_iv == '0) ? (min_change_frac <= FRAC_ONE) : (diff_scaled >= prod);
  assign apply       = enable && cool_ok && change_ok;

  // Capture the update and step the working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      threat  <= threat_next;
      factor  <= factor_next;
      cool_ok <= (CMP_BITS'(elapsed) >= CMP_BITS'(cooldown_ms));
      now_q   <= now_ms;
    end
    if (cmd.scale) begin
      scaled <= prod[PROD_BITS-1:Q16_SHIFT];
    end
    if (cmd.clamp) begin
      rec  <= rec_next;
      diff <= (cur_iv > rec_next) ? (cur_iv - rec_next) : (rec_next - cur_iv);
    end
  end

  // Commit the interval state
  always_ff @(posedge clk) begin
    if (rst) begin
      active_interval   <= '0;
      last_change_stamp <= '0;
      stored_threat     <= THREAT_LOW;
    end else if (cmd.commit) begin
      if (enable) stored_threat <= threat;
      if (apply) begin
        active_interval   <= rec;
        last_change_stamp <= now_q;
      end
    end
  end

  // Hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.commit) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      threat_level         <= enable ? threat : stored_threat;
      recommended_interval <= enable ? rec : '0;
      interval_applied     <= apply;
      if (apply) begin
        current_interval <= (rec != '0) ? rec : base_interval;
      end else begin
        current_interval <= cur_iv;
      end
    end
  end

  assign sts.out_free = !res_valid || res_ready;

endmodule

// ===== verif/apic_interval_checker.sv =====
// ----------------------------------------------------------------------------
// apic_interval_checker
// Watches the configuration, update and result channels of the adaptive
// poll interval controller. Keeps its own copy of the registers and of the
// interval state, works out the outcome of every accepted update and
// compares each result transfer against the oldest outcome still owed.
// ----------------------------------------------------------------------------
module apic_interval_checker
  import apic_pkg::*;
#(
  parameter int INTERVAL_BITS = 20,
  parameter int TIME_BITS     = 32
) (
  input  logic clk,
  input  logic rst,
  apic_cfg_if  cfg,
  apic_upd_if  upd,
  apic_res_if  res,
  output int   mismatches,
  output int   outstanding
);

  localparam int          REPORT_LIMIT = 10;
  localparam logic [16:0] FRAC_UNITY   = 17'd65536;

  typedef logic [INTERVAL_BITS-1:0] ivl_t;
  typedef logic [TIME_BITS-1:0]     stamp_t;

  typedef struct {
    threat_t threat;
    ivl_t    rec;
    logic    applied;
    ivl_t    cur;
  } outcome_t;

  // Register copy
  logic        enable_r;
  ivl_t        base_r;
  ivl_t        min_r;
  ivl_t        max_r;
  logic [31:0] cooldown_r;
  logic [16:0] frac_r;
  logic [47:0] thresh_r;
  logic [31:0] cpulim_r;

  // Interval state copy
  ivl_t    active_r;
  stamp_t  stamp_r;
  threat_t threat_r;

  outcome_t interval_outcomes[$];

  function automatic threat_t rate_to_threat(logic [15:0] rate);
    if (rate >= thresh_r[47:32]) return THREAT_CRITICAL;
    if (rate >= thresh_r[31:16]) return THREAT_HIGH;
    if (rate >= thresh_r[15:0]) return THREAT_MEDIUM;
    return THREAT_LOW;
  endfunction

  // Q1.16 factor from threat and CPU band; hot wins over idle
  function automatic logic [16:0] interval_factor(threat_t tl, logic [15:0] cpu);
    logic hot;
    logic idle;
    hot  = (cpu >= cpulim_r[31:16]);
    idle = (cpu != 16'd0) && (cpu <= cpulim_r[15:0]) &&
           (tl == THREAT_HIGH || tl == THREAT_CRITICAL);
    case (tl)
      THREAT_LOW:    return hot ? 17'd98304 : 17'd65536;
      THREAT_MEDIUM: return hot ? 17'd68813 : 17'd45875;
      THREAT_HIGH:   return hot ? 17'd32440 : (idle ? 17'd17302 : 17'd21627);
      default:       return hot ? 17'd19661 : (idle ? 17'd10486 : 17'd13107);
    endcase
  endfunction

  // Grade one update, advance the interval state and return its outcome
  function automatic outcome_t grade_update(logic [15:0] rate, logic [15:0] cpu_raw,
                                            stamp_t now);
    outcome_t    o;
    logic [15:0] cpu;
    logic [63:0] scaled;
    logic [63:0] cur_iv;
    logic [63:0] diff;
    stamp_t      since;
    logic        ok;
    cpu       = cpu_raw[15] ? 16'd0 : cpu_raw;
    o.rec     = '0;
    o.applied = 1'b0;
    if (enable_r) begin
      threat_r = rate_to_threat(rate);
      scaled   = (64'(base_r) * 64'(interval_factor(threat_r, cpu))) >> 16;
      if (scaled < 64'(min_r)) scaled = 64'(min_r);
      if (scaled > 64'(max_r)) scaled = 64'(max_r);
      o.rec = ivl_t'(scaled);
      since = now - stamp_r;
      if (64'(since) >= 64'(cooldown_r)) begin
        cur_iv = (active_r != '0) ? 64'(active_r) : 64'(base_r);
        if (cur_iv == 64'd0) begin
          ok = (frac_r <= FRAC_UNITY);
        end else begin
          diff = (cur_iv > scaled) ? (cur_iv - scaled) : (scaled - cur_iv);
          ok   = ((diff << 16) >= 64'(frac_r) * cur_iv);
        end
        if (ok) begin
          active_r  = o.rec;
          stamp_r   = now;
          o.applied = 1'b1;
        end
      end
    end
    o.threat = threat_r;
    o.cur    = (active_r != '0) ? active_r : base_r;
    return o;
  endfunction

  function automatic void write_register(logic [2:0] idx, logic [47:0] value);
    case (apic_reg_t'(idx))
      REG_ENABLE:          enable_r   = value[0];
      REG_BASE_INTERVAL:   base_r     = value[INTERVAL_BITS-1:0];
      REG_MIN_INTERVAL:    min_r      = value[INTERVAL_BITS-1:0];
      REG_MAX_INTERVAL:    max_r      = value[INTERVAL_BITS-1:0];
      REG_COOLDOWN:        cooldown_r = value[31:0];
      REG_MIN_CHANGE_FRAC: frac_r     = value[16:0];
      REG_RATE_THRESHOLDS: thresh_r   = value;
      REG_CPU_LIMITS:      cpulim_r   = value[31:0];
      default: ;
    endcase
  endfunction

  function automatic void flag_failure(string what);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) $display("%0t: %s", $time, what);
  endfunction

  // Track registers, predict on update transfers, compare on result transfers
  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      enable_r   = 1'b1;
      base_r     = ivl_t'(1000);
      min_r      = ivl_t'(100);
      max_r      = ivl_t'(10000);
      cooldown_r = 32'd5000;
      frac_r     = 17'd6554;
      thresh_r   = 48'h1000_0400_0100;
      cpulim_r   = 32'h5000_1400;
      active_r   = '0;
      stamp_r    = '0;
      threat_r   = THREAT_LOW;
      interval_outcomes.delete();
    end else begin
      if (res.valid && res.ready) begin
        if (interval_outcomes.size() == 0) begin
          flag_failure($sformatf("result with none owed: threat=%0d rec=%0d applied=%0d cur=%0d",
                                 res.threat_level, res.recommended_interval,
                                 res.interval_applied, res.current_interval));
        end else begin
          want = interval_outcomes.pop_front();
          if (res.threat_level !== want.threat ||
              res.recommended_interval !== want.rec ||
              res.interval_applied !== want.applied ||
              res.current_interval !== want.cur) begin
            flag_failure($sformatf({"mismatch: expected threat=%0d rec=%0d applied=%0d ",
                                    "cur=%0d, got threat=%0d rec=%0d applied=%0d cur=%0d"},
                                   want.threat, want.rec, want.applied, want.cur,
                                   res.threat_level, res.recommended_interval,
                                   res.interval_applied, res.current_interval));
          end
        end
      end
      if (upd.valid && upd.ready)
        interval_outcomes.push_back(grade_update(upd.detection_rate, upd.cpu_percent,
                                                 upd.now_ms));
      if (cfg.valid && cfg.ready) write_register(cfg.index, cfg.data);
    end
    outstanding = interval_outcomes.size();
  end

endmodule

// ===== verif/adaptive_poll_interval_ctrl_core_tb.sv =====
// ----------------------------------------------------------------------------
// adaptive_poll_interval_ctrl_core_tb
// Drives the adaptive poll interval controller with directed updates for
// threat grading, CPU bands, clamping, cooldown, wraparound and disable,
// then with randomized register settings and update streams under random
// idling and back-pressure. Results are checked by apic_interval_checker.
// ----------------------------------------------------------------------------
module adaptive_poll_interval_ctrl_core_tb;
  import apic_pkg::*;

  localparam int LIMIT_CYCLES   = 400000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int PHASES         = 12;
  localparam int ITEMS_PER_PHASE = 70;

  logic clk = 1'b0;
  logic rst = 1'b1;

  int mismatches;
  int outstanding;
  int cycles = 0;
  int send_idle_pct = 30;
  int recv_idle_pct = 82;
  int res_hold_cycles = 0;

  // Stimulus-side view of registers that shape the random updates
  logic [47:0] thresh_w   = 48'h1000_0400_0100;
  logic [31:0] cpulim_w   = 32'h5000_1400;
  logic [31:0] cooldown_w = 32'd5000;
  logic [31:0] clock_ms   = 32'd0;

  apic_cfg_if cfg_if();
  apic_upd_if upd_if();
  apic_res_if res_if();

  adaptive_poll_interval_ctrl_core uut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_if),
    .upd (upd_if),
    .res (res_if)
  );

  apic_interval_checker chk (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg_if),
    .upd         (upd_if),
    .res         (res_if),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always #5 clk = ~clk;

  // Abort a run that hangs
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result receiver: random stalls plus an occasional long hold-off
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (res_hold_cycles > 0) begin
        res_hold_cycles--;
        res_if.ready = 1'b0;
      end else begin
        res_if.ready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic write_reg(input apic_reg_t idx, input logic [47:0] value);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = value;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid = 1'b0;
    case (idx)
      REG_COOLDOWN:        cooldown_w = value[31:0];
      REG_RATE_THRESHOLDS: thresh_w   = value;
      REG_CPU_LIMITS:      cpulim_w   = value[31:0];
      default: ;
    endcase
  endtask

  task automatic send_update(input logic [15:0] rate, input logic [15:0] cpu,
                             input logic [31:0] now);
    while ($urandom_range(99) < send_idle_pct) begin
      upd_if.valid = 1'b0;
      @(negedge clk);
    end
    upd_if.valid          = 1'b1;
    upd_if.detection_rate = rate;
    upd_if.cpu_percent    = cpu;
    upd_if.now_ms         = now;
    do @(posedge clk); while (!upd_if.ready);
    @(negedge clk);
    upd_if.valid = 1'b0;
  endtask

  // Wait for every owed result, then let the pipeline settle
  task automatic drain();
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Rate near a threshold most of the time, anywhere otherwise
  function automatic logic [15:0] pick_rate();
    int sel;
    sel = $urandom_range(2);
    if ($urandom_range(3) == 0) return 16'($urandom);
    return thresh_w[16*sel +: 16] + 16'($urandom_range(2)) - 16'd1;
  endfunction

  // CPU load within -100.0 .. +100.0, often near a band limit
  function automatic logic [15:0] pick_cpu();
    int v;
    case ($urandom_range(5))
      0: v = int'($urandom_range(51200)) - 25600;
      1: v = -int'($urandom_range(25600, 1));
      2: v = 0;
      5: v = int'($urandom_range(25600, 1));
      default: begin
        v = int'(cpulim_w[16*$urandom_range(1) +: 16]) + int'($urandom_range(2)) - 1;
        if (v < 0 || v > 25600) v = int'($urandom_range(25600));
      end
    endcase
    return 16'(v);
  endfunction

  // Advance time mostly in small steps or around the cooldown edge
  function automatic logic [31:0] pick_time();
    case ($urandom_range(9))
      0, 1, 2, 3: clock_ms = clock_ms + $urandom_range(200);
      4, 5, 6, 7: clock_ms = clock_ms + cooldown_w - 32'd2 + $urandom_range(4);
      8:          clock_ms = clock_ms + $urandom;
      default:    clock_ms = $urandom;
    endcase
    return clock_ms;
  endfunction

  // Draw a fresh register setting, extremes included
  task automatic shuffle_config();
    logic [19:0] b;
    logic [15:0] med;
    logic [15:0] hi;
    logic [15:0] lo;
    write_reg(REG_ENABLE, 48'($urandom_range(7) != 0));
    case ($urandom_range(7))
      0:       b = 20'd0;
      1:       b = 20'hFFFFF;
      default: b = 20'($urandom_range(4000, 1));
    endcase
    write_reg(REG_BASE_INTERVAL, 48'(b));
    case ($urandom_range(7))
      0:       write_reg(REG_MIN_INTERVAL, 48'd0);
      1:       write_reg(REG_MIN_INTERVAL, 48'hFFFFF);
      default: write_reg(REG_MIN_INTERVAL, 48'($urandom_range(b / 2)));
    endcase
    case ($urandom_range(7))
      0:       write_reg(REG_MAX_INTERVAL, 48'd0);
      1:       write_reg(REG_MAX_INTERVAL, 48'hFFFFF);
      default: write_reg(REG_MAX_INTERVAL, 48'(20'(b + $urandom_range(b))));
    endcase
    case ($urandom_range(7))
      0:       write_reg(REG_COOLDOWN, 48'd0);
      1:       write_reg(REG_COOLDOWN, 48'hFFFF_FFFF);
      default: write_reg(REG_COOLDOWN, 48'($urandom_range(3000)));
    endcase
    case ($urandom_range(7))
      0:       write_reg(REG_MIN_CHANGE_FRAC, 48'd0);
      1:       write_reg(REG_MIN_CHANGE_FRAC, 48'd65536);
      default: write_reg(REG_MIN_CHANGE_FRAC, 48'($urandom_range(20000)));
    endcase
    if ($urandom_range(5) == 0) begin
      write_reg(REG_RATE_THRESHOLDS, {16'($urandom), 32'($urandom)});
    end else begin
      med = 16'($urandom_range(16'h0400));
      hi  = med + 16'($urandom_range(16'h0800));
      write_reg(REG_RATE_THRESHOLDS, {hi + 16'($urandom_range(16'h2000)), hi, med});
    end
    if ($urandom_range(5) == 0) begin
      write_reg(REG_CPU_LIMITS, 48'($urandom));
    end else begin
      lo = 16'($urandom_range(16'h3000));
      write_reg(REG_CPU_LIMITS, 48'({lo + 16'($urandom_range(16'h4000)), lo}));
    end
  endtask

  initial begin
    cfg_if.valid          = 1'b0;
    cfg_if.index          = REG_ENABLE;
    cfg_if.data           = '0;
    upd_if.valid          = 1'b0;
    upd_if.detection_rate = '0;
    upd_if.cpu_percent    = '0;
    upd_if.now_ms         = '0;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    // Threat grading, CPU bands, cooldown edge and time wrap at reset values
    send_update(16'h0000, 16'h0000, 32'd0);
    send_update(16'h00FF, 16'hFFFF, 32'd4999);
    send_update(16'h0100, 16'h1400, 32'd5000);
    send_update(16'h03FF, 16'h1400, 32'd5001);
    send_update(16'h0400, 16'h1400, 32'd10000);
    send_update(16'h0FFF, 16'h0001, 32'd15000);
    send_update(16'h1000, 16'h4FFF, 32'd20000);
    send_update(16'hFFFF, 16'h5000, 32'd25000);
    send_update(16'h0000, 16'h6400, 32'd30000);
    send_update(16'h0000, 16'h9C00, 32'd35000);
    send_update(16'h1000, 16'h1401, 32'hFFFF_FFFF);
    send_update(16'h0400, 16'h0000, 32'h0000_0100);

    // Disabled: state holds, nothing applied
    drain();
    write_reg(REG_ENABLE, 48'd0);
    send_update(16'hFFFF, 16'h5000, 32'h8000_0000);
    send_update(16'h0000, 16'h0001, 32'h9000_0000);
    drain();
    write_reg(REG_ENABLE, 48'd1);

    // Crossed limits: max clamp wins
    write_reg(REG_MIN_INTERVAL, 48'd5000);
    write_reg(REG_MAX_INTERVAL, 48'd300);
    send_update(16'h0000, 16'h0000, 32'hA000_0000);

    // Zero base and zero current interval
    drain();
    write_reg(REG_BASE_INTERVAL, 48'd0);
    write_reg(REG_MIN_INTERVAL, 48'd0);
    write_reg(REG_MAX_INTERVAL, 48'hFFFFF);
    write_reg(REG_COOLDOWN, 48'd0);
    write_reg(REG_MIN_CHANGE_FRAC, 48'd65536);
    send_update(16'h0100, 16'h0000, 32'd1);
    send_update(16'h0100, 16'h0000, 32'd1);
    drain();
    write_reg(REG_MIN_CHANGE_FRAC, 48'd0);
    send_update(16'h1000, 16'h0000, 32'd2);

    // Widest base, hot CPU: scaled value overflows the max clamp
    drain();
    write_reg(REG_BASE_INTERVAL, 48'hFFFFF);
    send_update(16'h0000, 16'h5000, 32'd3);
    send_update(16'hFFFF, 16'h0001, 32'd4);

    // Random settings and update streams
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      send_idle_pct = (ph < 4) ? 30 : ((ph < 8) ? 82 : 0);
      recv_idle_pct = (ph < 4) ? 82 : ((ph < 8) ? 30 : 0);
      shuffle_config();
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        // hold off the receiver while updates keep coming
        if (ph == 9 && k == 10) res_hold_cycles = 300;
        // pause the sender until nothing is owed
        if (k == ITEMS_PER_PHASE / 2) begin
          while (outstanding != 0) @(negedge clk);
        end
        send_update(pick_rate(), pick_cpu(), pick_time());
      end
    end

    drain();
    if (mismatches == 0 && outstanding == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
